// ----- src/tmie_pkg.sv -----
// ----------------------------------------------------------------------------
// tmie_pkg
// Shared types and constants for the tape machine instruction executor.
// ----------------------------------------------------------------------------
package tmie_pkg;

  localparam int TAPE_CELLS = 32768;
  localparam int PC_BITS    = 16;
  localparam int PTR_BITS   = $clog2(TAPE_CELLS);
  localparam int ARG_BITS   = 16;
  localparam int SUM_BITS   = ((PTR_BITS > ARG_BITS) ? PTR_BITS : ARG_BITS) + 1;

  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_IN    = 4'd1,
    OP_OUT   = 4'd2,
    OP_INCV  = 4'd3,
    OP_DECV  = 4'd4,
    OP_ADDV  = 4'd5,
    OP_SUBV  = 4'd6,
    OP_INCP  = 4'd7,
    OP_DECP  = 4'd8,
    OP_ADDP  = 4'd9,
    OP_SUBP  = 4'd10,
    OP_BRZ   = 4'd11,
    OP_BRNZ  = 4'd12,
    OP_JMP   = 4'd13,
    OP_HALT  = 4'd14,
    OP_CLEAR = 4'd15
  } op_e;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        halted;
  } res_t;

endpackage

// ----- src/tape_machine_instruction_executor_core.sv -----
// ----------------------------------------------------------------------------
// tape_machine_instruction_executor_core
// Executes one byte-tape machine instruction per item against an on-chip tape.
//
//   channel  dir  tdata (low bit up)                    tuser
//   s_axis   in   cmd[3:0] argument[19:4] in_byte[27:20]  in_eof
//   m_axis   out  next_pc[15:0] out_byte[23:16]         out_valid, halted
//
// one item per cycle unless stalled; each result is registered in the output buffer
// the tape is a single-port-write, single-read synchronous ram; the current
// cell is cached in a register, a pointer move reloads it from the ram
// after reset a clearing pass writes zeros over all 32768 cells, one a cycle,
// while s_axis_tready_o is low
// input stalls during the clearing pass or when both result registers are full
// ----------------------------------------------------------------------------
module tape_machine_instruction_executor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // cmd, argument, in_byte, zero pad
  input  logic        s_axis_tuser_i,  // in_eof
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // next_pc, out_byte
  output logic [1:0]  m_axis_tuser_o   // out_valid, halted
);

  localparam int PtrBits = tmie_pkg::PTR_BITS;
  localparam int PcBits  = tmie_pkg::PC_BITS;
  localparam int SumBits = tmie_pkg::SUM_BITS;

  logic [7:0] tape_mem [tmie_pkg::TAPE_CELLS];

  logic               clr_busy_q;
  logic [PtrBits-1:0] clr_addr_q;
  logic [PtrBits-1:0] ptr_q, ptr_d;
  logic [PcBits-1:0]  pc_q, pc_d;
  logic [7:0]         cell_q, cell_d;
  logic               cell_sel_q;
  logic [7:0]         rd_q;

  tmie_pkg::op_e   op;
  logic [15:0]     arg;
  logic [7:0]      in_byte;
  logic            in_eof;
  logic            acc;
  logic            buf_ready;
  logic [7:0]      cur_cell;
  logic            cell_wr;
  logic            ptr_move;
  logic [SumBits-1:0] ptr_sum;
  logic [7:0]      out_byte;
  logic            out_valid, halted;
  logic            tape_we, tape_re;
  logic [PtrBits-1:0] tape_waddr;
  logic [7:0]      tape_wdata;
  tmie_pkg::res_t  res, res_out;

  assign op      = tmie_pkg::op_e'(s_axis_tdata_i[3:0]);
  assign arg     = s_axis_tdata_i[19:4];
  assign in_byte = s_axis_tdata_i[27:20];
  assign in_eof  = s_axis_tuser_i;

  assign s_axis_tready_o = buf_ready & ~clr_busy_q;
  assign acc             = s_axis_tvalid_i & s_axis_tready_o;
  assign cur_cell        = cell_sel_q ? rd_q : cell_q;
  assign ptr_sum         = SumBits'(ptr_q) + SumBits'(arg);

  always_comb begin
    ptr_d     = ptr_q;
    pc_d      = pc_q + PcBits'(1);
    cell_d    = cur_cell;
    cell_wr   = 1'b0;
    ptr_move  = 1'b0;
    out_byte  = 8'd0;
    out_valid = 1'b0;
    halted    = 1'b0;
    unique case (op)
      tmie_pkg::OP_NOP: ;
      tmie_pkg::OP_IN: begin
        if (!in_eof) begin
          cell_d  = in_byte;
          cell_wr = 1'b1;
        end
      end
      tmie_pkg::OP_OUT: begin
        out_byte  = cur_cell;
        out_valid = 1'b1;
      end
      tmie_pkg::OP_INCV: begin
        cell_d  = cur_cell + 8'd1;
        cell_wr = 1'b1;
      end
      tmie_pkg::OP_DECV: begin
        cell_d  = cur_cell - 8'd1;
        cell_wr = 1'b1;
      end
      tmie_pkg::OP_ADDV: begin
        cell_d  = cur_cell + arg[7:0];
        cell_wr = 1'b1;
      end
      tmie_pkg::OP_SUBV: begin
        cell_d  = cur_cell - arg[7:0];
        cell_wr = 1'b1;
      end
      tmie_pkg::OP_INCP: begin
        ptr_move = 1'b1;
        if (ptr_q != PtrBits'(tmie_pkg::TAPE_CELLS - 1)) begin
          ptr_d = ptr_q + PtrBits'(1);
        end
      end
      tmie_pkg::OP_DECP: begin
        ptr_move = 1'b1;
        if (ptr_q != '0) begin
          ptr_d = ptr_q - PtrBits'(1);
        end
      end
      tmie_pkg::OP_ADDP: begin
        ptr_move = 1'b1;
        if (ptr_sum < SumBits'(tmie_pkg::TAPE_CELLS)) begin
          ptr_d = ptr_sum[PtrBits-1:0];
        end
      end
      tmie_pkg::OP_SUBP: begin
        ptr_move = 1'b1;
        if (SumBits'(arg) <= SumBits'(ptr_q)) begin
          ptr_d = PtrBits'(SumBits'(ptr_q) - SumBits'(arg));
        end
      end
      tmie_pkg::OP_BRZ: begin
        if (cur_cell == 8'd0) begin
          pc_d = PcBits'(arg);
        end
      end
      tmie_pkg::OP_BRNZ: begin
        if (cur_cell != 8'd0) begin
          pc_d = PcBits'(arg);
        end
      end
      tmie_pkg::OP_JMP: pc_d = PcBits'(arg);
      tmie_pkg::OP_HALT: begin
        pc_d   = pc_q;
        halted = 1'b1;
      end
      tmie_pkg::OP_CLEAR: begin
        cell_d  = 8'd0;
        cell_wr = 1'b1;
      end
      default: ;
    endcase
  end

  // ram port control: clearing pass or cell write-back; read on pointer move
  assign tape_we    = clr_busy_q | (acc & cell_wr);
  assign tape_waddr = clr_busy_q ? clr_addr_q : ptr_q;
  assign tape_wdata = clr_busy_q ? 8'd0 : cell_d;
  assign tape_re    = acc & ptr_move;

  always_ff @(posedge clk_i) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
    if (tape_re) begin
      rd_q <= tape_mem[ptr_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      ptr_q      <= '0;
      pc_q       <= '0;
      cell_q     <= 8'd0;
      cell_sel_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + PtrBits'(1);
        if (clr_addr_q == PtrBits'(tmie_pkg::TAPE_CELLS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (acc) begin
        ptr_q      <= ptr_d;
        pc_q       <= pc_d;
        cell_q     <= cell_d;
        cell_sel_q <= ptr_move;
      end
    end
  end

  assign res.next_pc   = 16'(pc_d);
  assign res.out_byte  = out_byte;
  assign res.out_valid = out_valid;
  assign res.halted    = halted;

  tmie_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (acc),
    .data_i       (res),
    .ready_o      (buf_ready),
    .valid_o      (m_axis_tvalid_o),
    .take_ready_i (m_axis_tready_i),
    .data_o       (res_out)
  );

  assign m_axis_tdata_o = {res_out.out_byte, res_out.next_pc};
  assign m_axis_tuser_o = {res_out.halted, res_out.out_valid};

`ifndef SYNTH
  a_no_accept_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_busy_q |-> !s_axis_tready_o)
    else $error("item accepted during tape clearing pass");

  a_no_read_write_overlap: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(tape_we && tape_re))
    else $error("tape read and write in the same cycle");

  a_move_reloads_cell: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (acc && ptr_move) |=> cell_sel_q)
    else $error("pointer move did not select ram data for the cell");

  a_halt_no_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> !m_axis_tuser_o[0])
    else $error("halt result carries an output byte");

  a_ptr_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    acc |=> (PtrBits+1)'(ptr_q) < (PtrBits+1)'(tmie_pkg::TAPE_CELLS))
    else $error("cell pointer left the tape");
`endif

endmodule

// ----- src/tmie_out_buf.sv -----
// ----------------------------------------------------------------------------
// tmie_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module tmie_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tmie_pkg::res_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          take_ready_i,
  output tmie_pkg::res_t data_o
);

  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  tmie_pkg::res_t out_q, skid_q;
  logic           take;
  logic           load_out, load_skid;

  assign take    = out_valid_q & take_ready_i;
  assign ready_o = ~skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    if (skid_valid_q) begin
      if (take) begin
        load_out     = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end
    if (load_skid) begin
      skid_q <= data_i;
    end
  end

endmodule
